// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/icy_md_pkg.sv =====
// Shared types, constants and tables of the ICY metadata deframer.
package icy_md_pkg;

  localparam int INTERVAL_BITS = 24;
  localparam int LEN_UNIT      = 16;
  localparam int POS_BITS      = 12;

  localparam logic [POS_BITS-1:0] PREFIX_LEN  = POS_BITS'(13);
  localparam logic [POS_BITS-1:0] TAG_MIN_LEN = POS_BITS'(14);

  localparam logic [1:0] KIND_AUDIO   = 2'd0;
  localparam logic [1:0] KIND_LEN     = 2'd1;
  localparam logic [1:0] KIND_CONTENT = 2'd2;

  // register index, taken from word address bit 2
  localparam logic REG_INTERVAL = 1'b0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  typedef struct packed {
    logic                enable;
    logic                clear;
    logic                last;
    logic                len_ok;
    logic [POS_BITS-1:0] pos;
  } scan_ctl_t;

  typedef struct packed {
    logic                title_tag;
    logic                end_found;
    logic                dash_found;
    logic [POS_BITS-1:0] artist_stop;
    logic [POS_BITS-1:0] title_begin;
    logic [POS_BITS-1:0] title_stop;
  } report_t;

  // Lower-case text of "StreamTitle='".
  function automatic logic [7:0] tag_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h73;
      4'd1:    c = 8'h74;
      4'd2:    c = 8'h72;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6d;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h74;
      4'd9:    c = 8'h6c;
      4'd10:   c = 8'h65;
      4'd11:   c = 8'h3d;
      4'd12:   c = 8'h27;
      default: c = 8'hff;
    endcase
    return c;
  endfunction

endpackage

// ===== src/icy_metadata_deframer_top.sv =====
// Top level of the ICY metadata deframer: config register, framing, scan, result register.
// The result of a byte is registered and shows on the output in the cycle after its transaction.
// Throughput: one byte per cycle; in_stall rises only while a held result is stalled.
// The framing counters update with every taken byte; the title scanner with each taken length or content byte.
// Reset (rst, synchronous): interval register 0, audio phase, scanner cleared, output empty.
// A write to the interval register restarts framing in the audio phase with the new value.
module icy_metadata_deframer_top import icy_md_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          stream_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic [1:0]          byte_kind,
  output logic [POS_BITS-1:0] block_pos,
  output logic                block_end,
  output logic                title_tag,
  output logic                end_found,
  output logic                dash_found,
  output logic [POS_BITS-1:0] artist_stop,
  output logic [POS_BITS-1:0] title_begin,
  output logic [POS_BITS-1:0] title_stop
);

  logic [INTERVAL_BITS-1:0] audio_interval;
  logic                     cfg_wr;
  logic                     take;
  scan_ctl_t                ctl;
  report_t                  rpt;
  logic [1:0]               kind_c;
  logic [POS_BITS-1:0]      pos_c;
  logic                     bend_c;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready && paddr[2] == REG_INTERVAL;
  assign prdata   = (paddr[2] == REG_INTERVAL) ? 32'(audio_interval) : '0;
  assign in_stall = out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_interval <= '0;
    end else if (cfg_wr) begin
      audio_interval <= pwdata[INTERVAL_BITS-1:0];
    end
  end

  icy_md_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .cfg_wr       (cfg_wr),
    .cfg_interval (pwdata[INTERVAL_BITS-1:0]),
    .interval     (audio_interval),
    .stream_byte  (stream_byte),
    .byte_kind    (kind_c),
    .block_pos    (pos_c),
    .block_end    (bend_c),
    .ctl          (ctl)
  );

  icy_md_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .cfg_wr      (cfg_wr),
    .stream_byte (stream_byte),
    .ctl         (ctl),
    .rpt         (rpt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte    <= stream_byte;
      byte_kind   <= kind_c;
      block_pos   <= pos_c;
      block_end   <= bend_c;
      title_tag   <= rpt.title_tag;
      end_found   <= rpt.end_found;
      dash_found  <= rpt.dash_found;
      artist_stop <= rpt.artist_stop;
      title_begin <= rpt.title_begin;
      title_stop  <= rpt.title_stop;
    end
  end

endmodule

// ===== src/icy_md_frame.sv =====
// Framing counters: audio run, length byte and metadata block position.
module icy_md_frame import icy_md_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic                     cfg_wr,
  input  logic [INTERVAL_BITS-1:0] cfg_interval,
  input  logic [INTERVAL_BITS-1:0] interval,
  input  logic [7:0]               stream_byte,
  output logic [1:0]               byte_kind,
  output logic [POS_BITS-1:0]      block_pos,
  output logic                     block_end,
  output scan_ctl_t                ctl
);

  localparam logic PH_AUDIO   = 1'b0;
  localparam logic PH_CONTENT = 1'b1;

  logic                     phase, phase_next;
  logic [INTERVAL_BITS-1:0] audio_left, audio_left_next;
  logic [POS_BITS-1:0]      content_left, content_left_next;
  logic [POS_BITS-1:0]      content_pos, content_pos_next;
  logic [POS_BITS-1:0]      block_length, block_length_next;
  logic [POS_BITS-1:0]      new_length;

  assign new_length = POS_BITS'({{(POS_BITS-8){1'b0}}, stream_byte} * POS_BITS'(LEN_UNIT));

  always_comb begin
    phase_next        = phase;
    audio_left_next   = audio_left;
    content_left_next = content_left;
    content_pos_next  = content_pos;
    block_length_next = block_length;
    byte_kind         = KIND_AUDIO;
    block_pos         = '0;
    block_end         = 1'b0;
    ctl               = '0;
    ctl.pos           = content_pos;
    ctl.len_ok        = block_length > TAG_MIN_LEN;
    unique case (phase)
      PH_CONTENT: begin
        byte_kind         = KIND_CONTENT;
        block_pos         = content_pos;
        ctl.enable        = 1'b1;
        content_pos_next  = content_pos + POS_BITS'(1);
        content_left_next = content_left - POS_BITS'(1);
        if (content_left == POS_BITS'(1)) begin
          ctl.last        = 1'b1;
          block_end       = 1'b1;
          phase_next      = PH_AUDIO;
          audio_left_next = interval;
        end
      end
      default: begin
        if (interval == '0 || audio_left != '0) begin
          if (audio_left != '0) begin
            audio_left_next = audio_left - INTERVAL_BITS'(1);
          end
        end else begin
          byte_kind         = KIND_LEN;
          ctl.clear         = 1'b1;
          content_pos_next  = '0;
          block_length_next = new_length;
          if (new_length == '0) begin
            block_end         = 1'b1;
            content_left_next = '0;
            audio_left_next   = interval;
          end else begin
            content_left_next = new_length;
            phase_next        = PH_CONTENT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_AUDIO;
      audio_left   <= '0;
      content_left <= '0;
      content_pos  <= '0;
      block_length <= '0;
    end else if (cfg_wr) begin
      phase        <= PH_AUDIO;
      audio_left   <= cfg_interval;
      content_left <= '0;
      content_pos  <= '0;
      block_length <= '0;
    end else if (take) begin
      phase        <= phase_next;
      audio_left   <= audio_left_next;
      content_left <= content_left_next;
      content_pos  <= content_pos_next;
      block_length <= block_length_next;
    end
  end

endmodule

// ===== src/icy_md_scan.sv =====
// Title tag scanner: prefix check, separator and end mark search, block report.
module icy_md_scan import icy_md_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       cfg_wr,
  input  logic [7:0] stream_byte,
  input  scan_ctl_t  ctl,
  output report_t    rpt
);

  logic                prefix_ok, prefix_ok_next;
  logic                mp_space, mp_space_next;
  logic                mp_spdash, mp_spdash_next;
  logic                mp_quote, mp_quote_next;
  logic [POS_BITS-1:0] dash_pos, dash_pos_next;
  logic [POS_BITS-1:0] qs_pos, qs_pos_next;
  logic [POS_BITS-1:0] fq_pos, fq_pos_next;
  logic                f_dash, f_dash_next;
  logic                f_qs, f_qs_next;
  logic                f_q, f_q_next;
  logic                nul_seen, nul_seen_next;
  logic [7:0]          lower;
  logic                char_ok;
  logic                end_found;
  logic [POS_BITS-1:0] end_pos;
  logic                dash_ok;

  assign lower   = (stream_byte >= 8'h41 && stream_byte <= 8'h5a) ?
                   (stream_byte | 8'h20) : stream_byte;
  assign char_ok = lower == tag_char(ctl.pos[3:0]);

  always_comb begin
    prefix_ok_next = prefix_ok;
    mp_space_next  = mp_space;
    mp_spdash_next = mp_spdash;
    mp_quote_next  = mp_quote;
    dash_pos_next  = dash_pos;
    qs_pos_next    = qs_pos;
    fq_pos_next    = fq_pos;
    f_dash_next    = f_dash;
    f_qs_next      = f_qs;
    f_q_next       = f_q;
    nul_seen_next  = nul_seen;
    if (ctl.pos < PREFIX_LEN) begin
      prefix_ok_next = (ctl.pos == '0) ? char_ok : (prefix_ok & char_ok);
    end else if (!nul_seen) begin
      if (stream_byte == CH_NUL) begin
        nul_seen_next  = 1'b1;
        mp_space_next  = 1'b0;
        mp_spdash_next = 1'b0;
        mp_quote_next  = 1'b0;
      end else begin
        if (stream_byte == CH_QUOTE && !f_q) begin
          fq_pos_next = ctl.pos;
          f_q_next    = 1'b1;
        end
        if (stream_byte == CH_SEMI && mp_quote && !f_qs) begin
          qs_pos_next = ctl.pos - POS_BITS'(1);
          f_qs_next   = 1'b1;
        end
        if (stream_byte == CH_SPACE && mp_spdash && !f_dash) begin
          dash_pos_next = ctl.pos - POS_BITS'(2);
          f_dash_next   = 1'b1;
        end
        mp_space_next  = stream_byte == CH_SPACE;
        mp_spdash_next = stream_byte == CH_DASH && mp_space;
        mp_quote_next  = stream_byte == CH_QUOTE;
      end
    end
  end

  // report is built from the state after the block's last byte
  assign end_found = f_qs_next | f_q_next;
  assign end_pos   = f_qs_next ? qs_pos_next : fq_pos_next;
  assign dash_ok   = f_dash_next && dash_pos_next < end_pos;

  always_comb begin
    rpt = '0;
    if (ctl.last && prefix_ok_next && ctl.len_ok) begin
      rpt.title_tag = 1'b1;
      if (end_found) begin
        rpt.end_found = 1'b1;
        if (dash_ok) begin
          rpt.dash_found  = 1'b1;
          rpt.artist_stop = dash_pos_next;
          rpt.title_begin = dash_pos_next + POS_BITS'(3);
          rpt.title_stop  = end_pos;
        end else begin
          rpt.artist_stop = end_pos;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr || (take && ctl.clear)) begin
      prefix_ok <= 1'b0;
      mp_space  <= 1'b0;
      mp_spdash <= 1'b0;
      mp_quote  <= 1'b0;
      dash_pos  <= '0;
      qs_pos    <= '0;
      fq_pos    <= '0;
      f_dash    <= 1'b0;
      f_qs      <= 1'b0;
      f_q       <= 1'b0;
      nul_seen  <= 1'b0;
    end else if (take && ctl.enable) begin
      prefix_ok <= prefix_ok_next;
      mp_space  <= mp_space_next;
      mp_spdash <= mp_spdash_next;
      mp_quote  <= mp_quote_next;
      dash_pos  <= dash_pos_next;
      qs_pos    <= qs_pos_next;
      fq_pos    <= fq_pos_next;
      f_dash    <= f_dash_next;
      f_qs      <= f_qs_next;
      f_q       <= f_q_next;
      nul_seen  <= nul_seen_next;
    end
  end

endmodule

// ===== src/icy_md_checker.sv =====
// Port-level checks of the ICY metadata deframer, bound to the top level.
`include "assert_macros.svh"

module icy_md_checker import icy_md_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [7:0]          out_byte,
  input logic [1:0]          byte_kind,
  input logic [POS_BITS-1:0] block_pos,
  input logic                block_end,
  input logic                title_tag,
  input logic                end_found,
  input logic                dash_found,
  input logic [POS_BITS-1:0] artist_stop,
  input logic [POS_BITS-1:0] title_begin,
  input logic [POS_BITS-1:0] title_stop
);

  logic no_report;
  logic dash_span_ok;

  assign no_report    = !title_tag && !end_found && !dash_found;
  assign dash_span_ok = title_begin == POS_BITS'(artist_stop + POS_BITS'(3)) &&
                        title_stop > artist_stop;

  `ASSERT_NEXT(a_take_gives_result, clk, rst, in_valid && !in_stall, out_valid)
  `ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && out_stall, out_valid && $stable(out_byte))
  `ASSERT_NOW(a_report_only_at_end, clk, rst, out_valid && !block_end, no_report)
  `ASSERT_NOW(a_audio_plain, clk, rst, out_valid && byte_kind == KIND_AUDIO, block_pos == '0 && !block_end)
  `ASSERT_NOW(a_dash_order, clk, rst, out_valid && dash_found, dash_span_ok)

endmodule

bind icy_metadata_deframer_top icy_md_checker u_checker (.*);
